// ----- hw/rtl/evad_pkg.sv -----
// Shared types, constants and helper functions for the energy voice activity detector.
package evad_pkg;

   localparam int WINDOW_BITS_DEFAULT = 16;

   localparam int SAMPLE_W      = 16;
   localparam int TIME_W        = 32;
   localparam int COUNT_W       = 32;
   localparam int REQ_DATA_W    = 48;
   localparam int RSP_DATA_W    = 40;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 31;
   localparam int WINLEN_W      = 16;
   localparam int MUL_W         = 32;
   localparam int MUL_STEPS     = 8;
   localparam int STEP_W        = 3;

   localparam logic [WINLEN_W-1:0]   WINDOW_LENGTH_RESET   = 16'd512;
   localparam logic [CSR_DATA_W-1:0] POWER_THRESHOLD_RESET = 31'd1073742;
   localparam logic [CSR_DATA_W-1:0] HOLD_TIME_RESET       = 31'd2000;
   localparam logic [CSR_DATA_W-1:0] LOCKOUT_TIME_RESET    = 31'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LENGTH,
      CSR_POWER_THRESHOLD,
      CSR_HOLD_TIME,
      CSR_LOCKOUT_TIME
   } csr_index_type;

   // Operations of the shared multiplier. The window test is built from eight
   // partial products in the order listed from MUL_FILL_SQ to MUL_THR_HI.
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_FILL_SQ,
      MUL_SQ_LO,
      MUL_SQ_HI,
      MUL_MAG_LL,
      MUL_MAG_LH,
      MUL_MAG_HH,
      MUL_THR_LO,
      MUL_THR_HI,
      MUL_SAMPLE
   } mul_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_MUL,
      ST_DRAIN,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       load_item;
      mul_op_type mul_op;
      logic       acc_clear;
      logic       decide;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic window_close;
      logic out_free;
      logic end_of_call;
   } status_type;

   function automatic mul_op_type test_op(input logic [STEP_W-1:0] step);
      mul_op_type op;
      case (step)
         3'd0: op = MUL_FILL_SQ;
         3'd1: op = MUL_SQ_LO;
         3'd2: op = MUL_SQ_HI;
         3'd3: op = MUL_MAG_LL;
         3'd4: op = MUL_MAG_LH;
         3'd5: op = MUL_MAG_HH;
         3'd6: op = MUL_THR_LO;
         3'd7: op = MUL_THR_HI;
         default: op = MUL_NONE;
      endcase
      return op;
   endfunction

   // True once the wrapping timestamp now has reached or passed mark.
   function automatic logic time_reached(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] mark);
      logic [TIME_W-1:0] diff;
      diff = now - mark;
      return ~diff[TIME_W-1];
   endfunction

endpackage

// ----- hw/rtl/evad_ctrl.sv -----
// Controller state machine that sequences sample intake, the window test and the result.
module evad_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  evad_pkg::status_type status,
   output evad_pkg::cmd_type    cmd
);
   import evad_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MUL_STEPS - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      req_tready    = 1'b0;
      cmd.load_item = 1'b0;
      cmd.mul_op    = MUL_NONE;
      cmd.acc_clear = 1'b0;
      cmd.decide    = 1'b0;
      cmd.load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // No request is taken while reset is held.
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load_item = 1'b1;
               state_in      = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.mul_op = MUL_SAMPLE;
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (status.window_close) begin
               cmd.acc_clear = 1'b1;
               step_in       = '0;
               state_in      = ST_MUL;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MUL: begin
            cmd.mul_op = test_op(step_ff);
            step_in    = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.end_of_call) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/evad_dp.sv -----
// Datapath: settings, window sums, shared multiplier, variance test, burst timers, result.
module evad_dp #(
   parameter int WINDOW_BITS = evad_pkg::WINDOW_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [evad_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [evad_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [evad_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [evad_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  evad_pkg::cmd_type                    cmd,
   output evad_pkg::status_type                 status
);
   import evad_pkg::*;

   localparam int SQ_W  = WINDOW_BITS + 30;
   localparam int SUM_W = WINDOW_BITS + 17;
   localparam int MAG_W = WINDOW_BITS + 16;
   localparam int F2_W  = 2 * WINDOW_BITS;
   localparam int ACC_W = 2 * WINDOW_BITS + 34;

   // Settings.
   logic [WINLEN_W-1:0]   window_length_ff;
   logic [CSR_DATA_W-1:0] power_threshold_ff;
   logic [CSR_DATA_W-1:0] hold_time_ff;
   logic [CSR_DATA_W-1:0] lockout_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff   <= WINDOW_LENGTH_RESET;
         power_threshold_ff <= POWER_THRESHOLD_RESET;
         hold_time_ff       <= HOLD_TIME_RESET;
         lockout_time_ff    <= LOCKOUT_TIME_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_LENGTH:   window_length_ff   <= csr_wdata[WINLEN_W-1:0];
            CSR_POWER_THRESHOLD: power_threshold_ff <= csr_wdata;
            CSR_HOLD_TIME:       hold_time_ff       <= csr_wdata;
            CSR_LOCKOUT_TIME:    lockout_time_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Window length folded to the window counter width; zero acts as one.
   logic [WINDOW_BITS+WINLEN_W-1:0] win_ext;
   logic [WINDOW_BITS-1:0]          win_raw, win;
   assign win_ext = {{WINDOW_BITS{1'b0}}, window_length_ff};
   assign win_raw = win_ext[WINDOW_BITS-1:0];
   assign win     = (win_raw == '0) ? WINDOW_BITS'(1) : win_raw;

   // Captured request.
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [TIME_W-1:0]          now_ff;
   logic                       eoc_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         sample_ff <= req_tdata[SAMPLE_W-1:0];
         now_ff    <= req_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
         eoc_ff    <= req_tlast;
      end
   end

   // Window sums.
   logic [SQ_W-1:0]         square_sum_ff;
   logic signed [SUM_W-1:0] plain_sum_ff;
   logic [WINDOW_BITS-1:0]  fill_ff;
   logic [F2_W-1:0]         f2_ff;
   logic [MAG_W-1:0]        sum_mag;
   logic [SAMPLE_W-1:0]     sample_mag;

   assign sample_mag = sample_ff[SAMPLE_W-1] ? SAMPLE_W'(~sample_ff + 1'b1) : sample_ff;
   assign sum_mag    = plain_sum_ff[SUM_W-1] ? MAG_W'(-plain_sum_ff) : MAG_W'(plain_sum_ff);

   // Shared multiplier with its operation tag carried alongside the product.
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] prod_ff;
   mul_op_type         prod_op_ff;
   logic [2*MUL_W-1:0] sq_ext, mag_ext, f2_ext;

   assign sq_ext  = (2*MUL_W)'(square_sum_ff);
   assign mag_ext = (2*MUL_W)'(sum_mag);
   assign f2_ext  = (2*MUL_W)'(f2_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         MUL_SAMPLE: begin
            mul_a = MUL_W'(sample_mag);
            mul_b = MUL_W'(sample_mag);
         end
         MUL_FILL_SQ: begin
            mul_a = MUL_W'(fill_ff);
            mul_b = MUL_W'(fill_ff);
         end
         MUL_SQ_LO: begin
            mul_a = MUL_W'(fill_ff);
            mul_b = sq_ext[MUL_W-1:0];
         end
         MUL_SQ_HI: begin
            mul_a = MUL_W'(fill_ff);
            mul_b = sq_ext[2*MUL_W-1:MUL_W];
         end
         MUL_MAG_LL: begin
            mul_a = mag_ext[MUL_W-1:0];
            mul_b = mag_ext[MUL_W-1:0];
         end
         MUL_MAG_LH: begin
            mul_a = mag_ext[MUL_W-1:0];
            mul_b = mag_ext[2*MUL_W-1:MUL_W];
         end
         MUL_MAG_HH: begin
            mul_a = mag_ext[2*MUL_W-1:MUL_W];
            mul_b = mag_ext[2*MUL_W-1:MUL_W];
         end
         MUL_THR_LO: begin
            mul_a = MUL_W'(power_threshold_ff);
            mul_b = f2_ext[MUL_W-1:0];
         end
         MUL_THR_HI: begin
            mul_a = MUL_W'(power_threshold_ff);
            mul_b = f2_ext[2*MUL_W-1:MUL_W];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         prod_op_ff <= MUL_NONE;
      end else begin
         prod_op_ff <= cmd.mul_op;
      end
   end

   // Test accumulator: fill*square_sum - sum^2 - threshold*fill^2, signed.
   logic [6:0]         term_shift;
   logic               term_add, term_sub;
   logic [4*MUL_W-1:0] term_wide;
   logic [ACC_W-1:0]   term, acc_ff;
   logic               loud;

   always_comb begin
      term_shift = 7'd0;
      term_add   = 1'b0;
      term_sub   = 1'b0;
      case (prod_op_ff)
         MUL_SQ_LO:  term_add = 1'b1;
         MUL_SQ_HI: begin
            term_add   = 1'b1;
            term_shift = 7'd32;
         end
         MUL_MAG_LL: term_sub = 1'b1;
         MUL_MAG_LH: begin
            // The cross term appears twice in the square, hence one extra bit.
            term_sub   = 1'b1;
            term_shift = 7'd33;
         end
         MUL_MAG_HH: begin
            term_sub   = 1'b1;
            term_shift = 7'd64;
         end
         MUL_THR_LO: term_sub = 1'b1;
         MUL_THR_HI: begin
            term_sub   = 1'b1;
            term_shift = 7'd32;
         end
         default: ;
      endcase
   end

   assign term_wide = {{(2*MUL_W){1'b0}}, prod_ff} << term_shift;
   assign term      = term_wide[ACC_W-1:0];
   assign loud      = ~acc_ff[ACC_W-1];

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (term_add) begin
         acc_ff <= acc_ff + term;
      end else if (term_sub) begin
         acc_ff <= acc_ff - term;
      end
      if (prod_op_ff == MUL_FILL_SQ) begin
         f2_ff <= prod_ff[F2_W-1:0];
      end
   end

   // Burst and lockout timers.
   logic              burst_on_ff, locked_ff;
   logic [TIME_W-1:0] burst_end_ff, lockout_end_ff;
   logic [COUNT_W-1:0] burst_total_ff;
   logic              lock_mid, loud_ok, burst_mid, burst_done;
   logic [TIME_W-1:0] burst_end_mid;

   always_comb begin
      lock_mid      = locked_ff && !time_reached(now_ff, lockout_end_ff);
      loud_ok       = loud && !lock_mid;
      burst_mid     = burst_on_ff || loud_ok;
      burst_end_mid = loud_ok ? now_ff + TIME_W'(hold_time_ff) : burst_end_ff;
      burst_done    = burst_mid && time_reached(now_ff, burst_end_mid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         square_sum_ff  <= '0;
         plain_sum_ff   <= '0;
         fill_ff        <= '0;
         burst_on_ff    <= 1'b0;
         locked_ff      <= 1'b0;
         burst_end_ff   <= '0;
         lockout_end_ff <= '0;
         burst_total_ff <= '0;
      end else if (cmd.decide) begin
         square_sum_ff <= '0;
         plain_sum_ff  <= '0;
         fill_ff       <= '0;
         burst_on_ff   <= burst_mid && !burst_done;
         locked_ff     <= lock_mid || burst_done;
         burst_end_ff  <= burst_end_mid;
         if (burst_done) begin
            lockout_end_ff <= now_ff + TIME_W'(lockout_time_ff);
         end
         if (loud_ok && !burst_on_ff) begin
            burst_total_ff <= burst_total_ff + 1'b1;
         end
      end else if (prod_op_ff == MUL_SAMPLE) begin
         square_sum_ff <= square_sum_ff + SQ_W'(prod_ff[2*SAMPLE_W-2:0]);
         plain_sum_ff  <= plain_sum_ff + SUM_W'(sample_ff);
         fill_ff       <= fill_ff + 1'b1;
      end
   end

   // Result register.
   logic               rsp_valid_ff;
   logic               rsp_active_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_active_ff <= burst_on_ff;
         rsp_count_ff  <= burst_total_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_active_ff});

   assign status.window_close = ({1'b0, fill_ff} + 1'b1) >= {1'b0, win};
   assign status.out_free     = !rsp_valid_ff || rsp_tready;
   assign status.end_of_call  = eoc_ff;

   a_burst_lock_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(burst_on_ff && locked_ff))
      else $error("burst and lockout active together");

   a_count_only_on_decide : assert property (@(posedge clock) disable iff (reset)
      !cmd.decide |=> $stable(burst_total_ff))
      else $error("burst count changed outside a window test");

   a_window_cleared : assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> (fill_ff == '0) && (square_sum_ff == '0) && (plain_sum_ff == '0))
      else $error("window sums not cleared after test");

   a_no_result_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

endmodule

// ----- hw/rtl/energy_voice_activity_detector_top.sv -----
// Top level of the energy voice activity detector with hold and rearm lockout.
//
// Usage: each request on the req_ channel carries one signed 16-bit PCM sample
// and its millisecond timestamp; req_tlast marks the last sample of a buffer.
// Samples are summed, together with their squares, over a window of
// window_length samples. When a window closes its AC variance is tested
// exactly in integers against power_threshold; a loud window outside the
// lockout starts or extends a burst. Only a request with req_tlast set yields
// a response on the rsp_ channel, carrying speech_active and bursts_seen.
// A sample that does not close a window passes through the states SQUARE,
// ACCUM and FINISH before the next ready. A sample that closes a window also
// passes MUL, DRAIN and DECIDE, where the shared 32x32 multiplier forms the
// eight partial products of the variance test one per cycle. No new request is
// taken before the previous one is through; FINISH loads any response.
// Reset restores the register defaults and clears sums, timers and the count.
// A stalled receiver holds the response in the output register; the block keeps
// taking requests and only waits if a second response is due before then.
module energy_voice_activity_detector_top #(
   parameter int WINDOW_BITS = evad_pkg::WINDOW_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration write port.
   input  logic                             csr_we,
   input  logic [evad_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [evad_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [evad_pkg::REQ_DATA_W-1:0]  req_tdata,  // sample[15:0], time_ms[47:16]
   input  logic                             req_tlast,  // end_of_call
   // Response channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [evad_pkg::RSP_DATA_W-1:0]  rsp_tdata   // speech_active[0], bursts_seen[32:1]
);
   import evad_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller only sequences; all arithmetic and the detector state live in the datapath.
   evad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   evad_dp #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the energy voice activity detector top level.
module testbench;
   import evad_pkg::*;

   // One expected response: the burst flag and the running burst count.
   typedef struct packed {
      logic        active;
      logic [31:0] count;
   } expected_rsp_type;

   // The directed table mixes register writes and sample requests. A sample
   // row marked as typed carries its expected response written out by hand;
   // every other sample row is checked against the predictor below.
   typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type reg_sel;
      logic [30:0]   cfg_value;
      logic [15:0]   smp;
      logic [31:0]   ms;
      bit            last;
      bit            typed;
      bit            exp_on;
      logic [31:0]   exp_count;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 33;

   // The rows walk through the reset state, the extremes of the sample and
   // timestamp, a zero-length window, a zero threshold, a threshold of 2^30,
   // hold expiry, lockout blocking and its release, a timestamp that wraps,
   // the largest hold and lockout spans, a window shortened while partly
   // filled, and a window that lands exactly on the threshold.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h0000, 32'd0,        1, 1, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h7FFF, 32'hFFFFFFFF, 1, 1, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h8000, 32'd5,        0, 0, 0, 32'd0},
      '{ROW_WRITE,  CSR_WINDOW_LENGTH,   31'd0,          16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_WRITE,  CSR_POWER_THRESHOLD, 31'd0,          16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_WRITE,  CSR_HOLD_TIME,       31'd10,         16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_WRITE,  CSR_LOCKOUT_TIME,    31'd5,          16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h0000, 32'd100,      1, 1, 1, 32'd1},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h1234, 32'd110,      1, 1, 1, 32'd1},
      '{ROW_WRITE,  CSR_POWER_THRESHOLD, 31'h40000000,   16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h8000, 32'd115,      1, 1, 1, 32'd1},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h7FFF, 32'd120,      1, 1, 0, 32'd1},
      '{ROW_WRITE,  CSR_POWER_THRESHOLD, 31'd0,          16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h0000, 32'd124,      1, 1, 0, 32'd1},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h0000, 32'd125,      1, 1, 1, 32'd2},
      '{ROW_WRITE,  CSR_HOLD_TIME,       31'h7FFFFFFF,   16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h0000, 32'hFFFFFFF0, 1, 1, 1, 32'd2},
      '{ROW_WRITE,  CSR_LOCKOUT_TIME,    31'h7FFFFFFF,   16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_WRITE,  CSR_HOLD_TIME,       31'd0,          16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h0000, 32'd3,        1, 1, 0, 32'd2},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h0000, 32'h80000001, 1, 1, 0, 32'd2},
      '{ROW_WRITE,  CSR_WINDOW_LENGTH,   31'h7FFFFFFF,   16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h4000, 32'h80000005, 0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'hC000, 32'h80000006, 0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'hFFFF, 32'h80000007, 1, 1, 0, 32'd2},
      '{ROW_WRITE,  CSR_WINDOW_LENGTH,   31'd2,          16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h0001, 32'h80000008, 1, 0, 0, 32'd0},
      '{ROW_WRITE,  CSR_LOCKOUT_TIME,    31'd0,          16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_WRITE,  CSR_POWER_THRESHOLD, 31'd100,        16'h0000, 32'd0,        0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h000A, 32'd8,        0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'hFFF6, 32'd9,        1, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'h000A, 32'd20,       0, 0, 0, 32'd0},
      '{ROW_SAMPLE, CSR_WINDOW_LENGTH,   31'd0,          16'hFFF7, 32'd21,       1, 0, 0, 32'd0}
   };

   localparam int RANDOM_SAMPLES = 1750;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;   // sample[15:0], time_ms[47:16]
   logic                    req_tlast = 1'b0; // end_of_call
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;        // speech_active[0], bursts_seen[32:1]

   // Mirror of the configuration registers, at their reset values.
   logic [15:0] cfg_window    = WINDOW_LENGTH_RESET;
   logic [30:0] cfg_threshold = POWER_THRESHOLD_RESET;
   logic [30:0] cfg_hold      = HOLD_TIME_RESET;
   logic [30:0] cfg_lockout   = LOCKOUT_TIME_RESET;

   // Mirror of the detector state: window sums, burst and lockout timers.
   logic [45:0]        acc_sq           = '0;
   logic signed [32:0] acc_sum          = '0;
   logic [16:0]        acc_fill         = '0;
   bit                 burst_active     = 1'b0;
   bit                 lockout_active   = 1'b0;
   logic [31:0]        burst_deadline   = '0;
   logic [31:0]        lockout_deadline = '0;
   logic [31:0]        burst_count      = '0;

   // Responses still owed by the block, oldest first.
   expected_rsp_type due_status [$];
   int               mismatches = 0;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit               long_hold = 1'b0;

   energy_voice_activity_detector_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The timestamp wraps, so a deadline counts as reached when the 32-bit
   // difference from it is not negative.
   function automatic bit deadline_passed(input logic [31:0] now, input logic [31:0] mark);
      logic [31:0] diff;
      diff = now - mark;
      return !diff[31];
   endfunction

   // Advances the mirrored detector by one sample. It returns 1 when the
   // sample ends a buffer, with the response the block owes for it.
   function automatic bit advance_detector(input logic [15:0] smp, input logic [31:0] now,
                                           input bit last, output expected_rsp_type outcome);
      int                 value;
      int unsigned        mag;
      logic [16:0]        win;
      logic [32:0]        sum_mag;
      logic [127:0]       lhs;
      logic [127:0]       rhs;
      bit                 loud;
      value = int'($signed(smp));
      mag = (value < 0) ? -value : value;
      win = (cfg_window == 16'd0) ? 17'd1 : {1'b0, cfg_window};
      acc_sq   = acc_sq + 46'(mag * mag);
      acc_sum  = acc_sum + 33'(value);
      acc_fill = acc_fill + 17'd1;
      if (acc_fill >= win) begin
         // Exact variance test: fill*sumsq - sum^2 >= threshold*fill^2,
         // rearranged so that both sides stay non-negative.
         sum_mag = acc_sum[32] ? 33'(-acc_sum) : 33'(acc_sum);
         lhs = 128'(acc_fill) * 128'(acc_sq);
         rhs = 128'(sum_mag) * 128'(sum_mag)
             + 128'(cfg_threshold) * 128'(acc_fill) * 128'(acc_fill);
         loud = (lhs >= rhs);
         acc_sq   = '0;
         acc_sum  = '0;
         acc_fill = '0;
         // The lockout is only released when a window closes, and before
         // the loudness of that window is considered.
         if (lockout_active && deadline_passed(now, lockout_deadline))
            lockout_active = 1'b0;
         if (loud && !lockout_active) begin
            if (!burst_active) begin
               burst_active = 1'b1;
               burst_count  = burst_count + 32'd1;
            end
            burst_deadline = now + 32'(cfg_hold);
         end
         if (burst_active && deadline_passed(now, burst_deadline)) begin
            burst_active     = 1'b0;
            lockout_active   = 1'b1;
            lockout_deadline = now + 32'(cfg_lockout);
         end
      end
      outcome.active = burst_active;
      outcome.count  = burst_count;
      return last;
   endfunction

   // Offers one sample request and waits for its handshake. The valid stays
   // high afterwards, so a following request goes out without a gap.
   task automatic send_sample(input logic [15:0] smp, input logic [31:0] ms, input bit last,
                              input bit typed, input bit exp_on, input logic [31:0] exp_count);
      expected_rsp_type want;
      req_tvalid <= 1'b1;
      req_tdata  <= {ms, smp};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (advance_detector(smp, ms, last, want)) begin
         if (typed) begin
            want.active = exp_on;
            want.count  = exp_count;
         end
         due_status.push_back(want);
      end
   endtask

   // Drops the valid for a gap of the given number of cycles.
   task automatic pause(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every owed response has come. A sample
   // that ends no buffer may still be in flight, so a margin beyond the
   // longest window-close latency follows.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (due_status.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Writes one register. Only called while the block is idle.
   task automatic write_reg(input csr_index_type sel, input logic [30:0] value);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (sel)
         CSR_WINDOW_LENGTH:   cfg_window    = value[15:0];
         CSR_POWER_THRESHOLD: cfg_threshold = value;
         CSR_HOLD_TIME:       cfg_hold      = value;
         CSR_LOCKOUT_TIME:    cfg_lockout   = value;
         default: ;
      endcase
   endtask

   // Hold and lockout spans in milliseconds: mostly short against the
   // timestamp steps below, now and then zero or the largest span.
   function automatic logic [30:0] pick_span();
      case ($urandom_range(0, 7))
         0:       return 31'd0;
         1:       return 31'h7FFFFFFF;
         default: return 31'($urandom_range(0, 60));
      endcase
   endfunction

   // Each accepted response is compared field by field with the oldest
   // expectation.
   always @(posedge clock) begin
      expected_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_status.size() == 0) begin
            $error("response arrived with none expected: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            want = due_status.pop_front();
            if (rsp_tdata[0] !== want.active) begin
               $error("speech_active: expected %0d, actual %0d", want.active, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[32:1] !== want.count) begin
               $error("bursts_seen: expected %0d, actual %0d", want.count, rsp_tdata[32:1]);
               mismatches++;
            end
         end
      end
   end

   // The receiver mixes long ready stretches, random toggling and short
   // stalls. When asked, it holds off for a long stretch so that the output
   // register fills and the block has to stall its request channel.
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (250) @(posedge clock);
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  rsp_tready <= 1'b1;
                  repeat ($urandom_range(1, 60)) @(posedge clock);
               end
               1: begin
                  repeat ($urandom_range(1, 20)) begin
                     rsp_tready <= 1'($urandom_range(0, 1));
                     @(posedge clock);
                  end
               end
               2: begin
                  rsp_tready <= 1'b0;
                  repeat ($urandom_range(1, 10)) @(posedge clock);
               end
               default: begin
                  rsp_tready <= 1'b1;
                  repeat ($urandom_range(1, 5)) @(posedge clock);
               end
            endcase
         end
      end
   end

   // Main stimulus: reset, the directed table, then random phases.
   initial begin
      bit          after_write;
      bit          squeeze_phase;
      bit          no_gaps;
      int          phase;
      int          sent;
      int          burst_left;
      int          seg_left;
      int          seg_mode;
      int          amp;
      int          delta;
      logic [15:0] window_pick;
      logic [30:0] threshold_pick;
      logic [15:0] dc_level;
      logic [15:0] smp;
      logic [31:0] ms;
      bit          last;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register writes in the table are preceded by a full drain unless
      // they follow another write directly.
      after_write = 1'b0;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            if (!after_write)
               wait_for_quiet();
            write_reg(directed_rows[r].reg_sel, directed_rows[r].cfg_value);
            after_write = 1'b1;
         end else begin
            send_sample(directed_rows[r].smp, directed_rows[r].ms, directed_rows[r].last,
                        directed_rows[r].typed, directed_rows[r].exp_on,
                        directed_rows[r].exp_count);
            after_write = 1'b0;
         end
      end

      // Random phases. Each one drains the block, writes all four registers
      // and then sends segments of loud noise, quiet noise or a constant
      // level, so that windows fall on both sides of the threshold and
      // bursts start, extend, expire and run into the lockout.
      sent  = 0;
      phase = 0;
      ms    = $urandom;
      while (sent < RANDOM_SAMPLES) begin
         wait_for_quiet();
         case ($urandom_range(0, 7))
            0:       window_pick = 16'd0;
            1:       window_pick = 16'd1;
            2, 3, 4: window_pick = 16'($urandom_range(2, 16));
            5, 6:    window_pick = 16'($urandom_range(17, 64));
            default: window_pick = 16'($urandom_range(65, 400));
         endcase
         // The upper bits of a window length write carry noise the block
         // must ignore.
         write_reg(CSR_WINDOW_LENGTH, {15'($urandom), window_pick});
         case ($urandom_range(0, 5))
            0:       threshold_pick = 31'd0;
            1:       threshold_pick = 31'h40000000;
            default: threshold_pick = 31'($urandom_range(0, 1 << $urandom_range(0, 30)));
         endcase
         write_reg(CSR_POWER_THRESHOLD, threshold_pick);
         write_reg(CSR_HOLD_TIME, pick_span());
         write_reg(CSR_LOCKOUT_TIME, pick_span());

         if ($urandom_range(0, 3) == 0)
            ms = $urandom;
         // Two phases send nothing but buffer ends while the receiver holds
         // off, which backs the block up into its request channel.
         squeeze_phase = (phase == 2 || phase == 9);
         if (squeeze_phase)
            long_hold = 1'b1;
         no_gaps    = ($urandom_range(0, 3) == 0);
         burst_left = 0;
         seg_left   = 0;
         repeat ($urandom_range(30, 150)) begin
            if (seg_left == 0) begin
               seg_mode = $urandom_range(0, 2);
               seg_left = $urandom_range(1, 24);
               amp      = $urandom_range(0, 300);
               dc_level = 16'($urandom);
            end
            seg_left--;
            case (seg_mode)
               0: smp = 16'($urandom);
               1: begin
                  delta = $urandom_range(0, 2 * amp);
                  smp   = 16'(delta - amp);
               end
               default: smp = dc_level;
            endcase
            ms = ms + $urandom_range(0, 3);
            if ($urandom_range(0, 63) == 0)
               ms = $urandom;
            last = squeeze_phase || ($urandom_range(0, 3) == 0);
            if (!no_gaps && burst_left == 0) begin
               pause($urandom_range(0, 6));
               burst_left = $urandom_range(1, 24);
            end
            if (burst_left > 0)
               burst_left--;
            send_sample(smp, ms, last, 1'b0, 1'b0, 32'd0);
            sent++;
         end
         phase++;
      end

      wait_for_quiet();
      if (mismatches == 0 && due_status.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #4_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
